FILE: design/scac_pkg.sv
// Shared types and operation codes for the saturating counter array.
package scac_pkg;

  typedef enum logic [1:0] {
    KIND_INC   = 2'd0,
    KIND_DEC   = 2'd1,
    KIND_READ  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [9:0] cell_index;
    logic [3:0] amount;
  } request_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] count_value;
  } result_t;

endpackage

FILE: design/saturating_counter_array_core.sv
// Top level: counter array in one memory with read-modify-write and clear sweep.
// An accepted request is registered into s1; done and result register from s1.
// Throughput: increment, decrement and read take one request per cycle when not
// busy; a same-cell request right behind another is forwarded from the write
// register. Clear holds busy high in s1 and through the sweep, writing one cell
// per cycle. Reset: rst clears control, then a zeroing sweep holds busy high.
module saturating_counter_array_core #(
  parameter int COUNTER_WIDTH = 4,
  parameter int CELL_COUNT    = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  scac_pkg::request_t request,
  output logic               busy,
  output logic               done,
  output scac_pkg::result_t  result
);
  import scac_pkg::*;

  localparam int IDX_W = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

  logic [COUNTER_WIDTH-1:0] mem [CELL_COUNT];

  logic                     accept;
  logic                     req_in_range;
  logic [IDX_W-1:0]         req_addr;
  logic [COUNTER_WIDTH-1:0] rd_data;

  logic                     s1_valid;
  kind_t                    s1_kind;
  logic [IDX_W-1:0]         s1_addr;
  logic [COUNTER_WIDTH-1:0] s1_amt;
  logic                     s1_in_range;

  logic                     fw_valid;
  logic [IDX_W-1:0]         fw_addr;
  logic [COUNTER_WIDTH-1:0] fw_data;

  logic                     sweeping;
  logic [IDX_W-1:0]         sweep_addr;

  logic [COUNTER_WIDTH-1:0] cur;
  logic [COUNTER_WIDTH-1:0] upd_value;
  logic                     upd_ok;
  logic                     s1_clear;
  logic                     s1_write;
  logic                     we;
  logic [IDX_W-1:0]         waddr;
  logic [COUNTER_WIDTH-1:0] wdata;

  assign s1_clear     = s1_valid && (s1_kind == KIND_CLEAR);
  assign busy         = sweeping || s1_clear;
  assign accept       = start && !busy;
  assign req_in_range = (32'(request.cell_index) < 32'(CELL_COUNT));
  assign req_addr     = IDX_W'(request.cell_index);

  assign cur = (fw_valid && (fw_addr == s1_addr)) ? fw_data : rd_data;

  scac_update #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_update (
    .kind       (s1_kind),
    .cur        (cur),
    .amt        (s1_amt),
    .next_value (upd_value),
    .ok         (upd_ok)
  );

  assign s1_write = s1_valid && s1_in_range &&
                    ((s1_kind == KIND_INC) || (s1_kind == KIND_DEC));
  assign we       = sweeping || s1_write;
  assign waddr    = sweeping ? sweep_addr : s1_addr;
  assign wdata    = sweeping ? '0 : upd_value;

  always_ff @(posedge clk) begin
    rd_data <= mem[req_addr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      fw_valid   <= 1'b0;
      sweeping   <= 1'b1;
      sweep_addr <= '0;
      done       <= 1'b0;
    end else begin
      s1_valid <= accept;
      fw_valid <= s1_write;
      done     <= s1_valid;
      if (s1_clear) begin
        sweeping   <= 1'b1;
        sweep_addr <= '0;
      end else if (sweeping) begin
        if (sweep_addr == IDX_W'(CELL_COUNT - 1)) begin
          sweeping <= 1'b0;
        end
        sweep_addr <= sweep_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind     <= request.kind;
      s1_addr     <= req_addr;
      s1_amt      <= COUNTER_WIDTH'(request.amount);
      s1_in_range <= req_in_range;
    end
    fw_addr <= s1_addr;
    fw_data <= upd_value;
    if (s1_clear) begin
      result.ok          <= 1'b1;
      result.count_value <= '0;
    end else if (!s1_in_range) begin
      result.ok          <= 1'b0;
      result.count_value <= '0;
    end else begin
      result.ok          <= upd_ok;
      result.count_value <= 4'(upd_value);
    end
  end

endmodule

FILE: design/scac_update.sv
// Saturating increment, wrapping decrement and read update of one counter cell.
module scac_update #(
  parameter int COUNTER_WIDTH = 4
) (
  input  scac_pkg::kind_t           kind,
  input  logic [COUNTER_WIDTH-1:0]  cur,
  input  logic [COUNTER_WIDTH-1:0]  amt,
  output logic [COUNTER_WIDTH-1:0]  next_value,
  output logic                      ok
);
  import scac_pkg::*;

  logic [COUNTER_WIDTH:0] sum;

  assign sum = {1'b0, cur} + {1'b0, amt};

  always_comb begin
    next_value = cur;
    ok         = 1'b1;
    case (kind)
      KIND_INC: begin
        if (sum[COUNTER_WIDTH]) begin
          next_value = '1;
          ok         = 1'b0;
        end else begin
          next_value = sum[COUNTER_WIDTH-1:0];
        end
      end
      KIND_DEC: begin
        next_value = cur - amt;
        ok         = (cur >= amt);
      end
      default: begin
        next_value = cur;
        ok         = 1'b1;
      end
    endcase
  end

endmodule
